@@ hdl/bsqa_pkg.sv @@
// Package for the bounded server queue admission block.
// Holds the shared constants, controller states and command/status structs.
// No dependencies.
`default_nettype none

package bsqa_pkg;

	// Field widths
	localparam int TIME_W   = 32;
	localparam int FINISH_W = 48;
	localparam int LIMIT_W  = 4;

	// Default ring depth and register reset
	localparam int RING_SLOTS_DEF = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd15;

	// Saturation value of a finish time
	localparam logic [FINISH_W-1:0] FINISH_MAX = {FINISH_W{1'b1}};

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_CHECK
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture a request beat
		logic pop;     // retire the oldest entry
		logic decide;  // admit or reject, emit result
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pop_ok;  // oldest entry finished by the arrival time
	} dp_status_t;

endpackage

`default_nettype wire

@@ hdl/bsqa_ctrl.sv @@
// Controller for the bounded server queue admission block.
// Sequences capture, drain of finished entries and the admit decision.
// Depends on bsqa_pkg.
`default_nettype none

module bsqa_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  bsqa_pkg::dp_status_t  status,
	output bsqa_pkg::dp_cmd_t     cmd
);

	bsqa_pkg::ctrl_state_t state_q, state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsqa_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b0;
		unique case (state_q)
			bsqa_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = bsqa_pkg::ST_CHECK;
				end
			end
			bsqa_pkg::ST_CHECK: begin
				busy = 1'b1;
				// drain one finished entry per cycle, then decide
				if (status.pop_ok) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.decide = 1'b1;
					state_next = bsqa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bsqa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/bsqa_dp.sv @@
// Datapath for the bounded server queue admission block.
// Holds the finish-time ring memory, pointers, occupancy, limit register and result.
// Depends on bsqa_pkg.
`default_nettype none

module bsqa_dp #(
	parameter int RING_SLOTS = bsqa_pkg::RING_SLOTS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire  [bsqa_pkg::TIME_W-1:0]          arrival_time,
	input  wire  [bsqa_pkg::TIME_W-1:0]          service_time,
	input  wire                                  cfg_valid,
	input  wire  [bsqa_pkg::LIMIT_W-1:0]         cfg_data,
	input  bsqa_pkg::dp_cmd_t                    cmd,
	output bsqa_pkg::dp_status_t                 status,
	output logic                                 done,
	output logic                                 accepted,
	output logic [bsqa_pkg::FINISH_W-1:0]        finish_time
);

	localparam int IDX_W = $clog2(RING_SLOTS);
	localparam int OCC_W = $clog2(RING_SLOTS + 1);
	localparam int CMP_W = (OCC_W > bsqa_pkg::LIMIT_W) ? OCC_W : bsqa_pkg::LIMIT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SLOTS - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(RING_SLOTS);

	// Ring memory, no reset: only entries covered by occupancy are read
	logic [bsqa_pkg::FINISH_W-1:0] ring_mem [RING_SLOTS];
	logic [bsqa_pkg::FINISH_W-1:0] rd_q;

	logic [bsqa_pkg::TIME_W-1:0]   arrival_q, service_q;
	logic [bsqa_pkg::FINISH_W-1:0] last_q;
	logic [IDX_W-1:0]              head_q, tail_q;
	logic [OCC_W-1:0]              occ_q;
	logic [bsqa_pkg::LIMIT_W-1:0]  limit_q;

	logic [IDX_W-1:0]              head_next, tail_next, rd_addr;
	logic [bsqa_pkg::FINISH_W-1:0] base;
	logic [bsqa_pkg::FINISH_W:0]   sum;
	logic [bsqa_pkg::FINISH_W-1:0] finish_sat;
	logic                          admit;

	// Ring pointer increments
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	// Read port follows the head, one ahead while popping
	assign rd_addr = cmd.pop ? head_next : head_q;

	// Oldest entry done by arrival
	assign status.pop_ok = (occ_q != '0) &&
		(rd_q <= {{(bsqa_pkg::FINISH_W - bsqa_pkg::TIME_W){1'b0}}, arrival_q});

	// Admission check and saturating finish time
	assign admit = (CMP_W'(occ_q) <= CMP_W'(limit_q)) && (occ_q != OCC_FULL);
	assign base  = (occ_q == '0)
		? {{(bsqa_pkg::FINISH_W - bsqa_pkg::TIME_W){1'b0}}, arrival_q} : last_q;
	assign sum   = {1'b0, base} +
		{{(bsqa_pkg::FINISH_W + 1 - bsqa_pkg::TIME_W){1'b0}}, service_q};
	assign finish_sat = sum[bsqa_pkg::FINISH_W] ? bsqa_pkg::FINISH_MAX
		: sum[bsqa_pkg::FINISH_W-1:0];

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.decide && admit) begin
			ring_mem[tail_next] <= finish_sat;
		end
		rd_q <= ring_mem[rd_addr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arrival_q <= arrival_time;
			service_q <= service_time;
		end
		if (cmd.decide && admit) begin
			last_q <= finish_sat;
		end
		if (cmd.decide) begin
			accepted    <= admit;
			finish_time <= admit ? finish_sat : '0;
		end
	end

	// Control state: pointers, occupancy, limit, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= LAST_IDX;
			occ_q   <= '0;
			limit_q <= bsqa_pkg::LIMIT_RESET;
			done    <= 1'b0;
		end else begin
			done <= cmd.decide;
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.pop) begin
				head_q <= head_next;
				occ_q  <= occ_q - 1'b1;
			end else if (cmd.decide && admit) begin
				tail_q <= tail_next;
				occ_q  <= occ_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/bounded_server_queue_admission.sv @@
// Admission control for one server with a bounded queue of finish times.
// After start is taken, the block drains finished entries, then decides; done is registered from the decision.
// It takes no new request while busy; the drain pops one ring entry per cycle
// through the single registered read port of the ring memory.
// Reset clears head and occupancy, sets the tail to the last slot and the limit to 15; ring contents are not cleared.
// The receiver cannot stall: done is high for a single cycle; accepted and finish_time hold until the next decision.
`default_nettype none

module bounded_server_queue_admission #(
	parameter int RING_SLOTS = bsqa_pkg::RING_SLOTS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [bsqa_pkg::TIME_W-1:0]         arrival_time,
	input  wire  [bsqa_pkg::TIME_W-1:0]         service_time,
	output logic                                done,
	output logic                                accepted,
	output logic [bsqa_pkg::FINISH_W-1:0]       finish_time,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bsqa_pkg::LIMIT_W-1:0]        cfg_data
);

	bsqa_pkg::dp_cmd_t    cmd;
	bsqa_pkg::dp_status_t status;

	// Limit register takes a beat in any cycle
	assign cfg_ready = 1'b1;

	bsqa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	bsqa_dp #(
		.RING_SLOTS (RING_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.arrival_time (arrival_time),
		.service_time (service_time),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.done         (done),
		.accepted     (accepted),
		.finish_time  (finish_time)
	);

endmodule

`default_nettype wire
